// ===== hdl/hrhp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request header parser package
// Shared types, parse phases, status codes and keyword tables of the parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

    typedef enum logic [10:0] {
        PH_METHOD    = 11'b000_0000_0001,
        PH_GAP1      = 11'b000_0000_0010,
        PH_PREFIX    = 11'b000_0000_0100,
        PH_HOST      = 11'b000_0000_1000,
        PH_PATH      = 11'b000_0001_0000,
        PH_GAP2      = 11'b000_0010_0000,
        PH_VERSION   = 11'b000_0100_0000,
        PH_HDR_START = 11'b000_1000_0000,
        PH_HDR_NAME  = 11'b001_0000_0000,
        PH_HDR_GAP   = 11'b010_0000_0000,
        PH_HDR_VALUE = 11'b100_0000_0000
    } phase_t;

    localparam logic [1:0] ST_MORE     = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_BAD      = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [3:0] LEN_GET   = 4'd3;
    localparam logic [3:0] LEN_POST  = 4'd4;
    localparam logic [3:0] LEN_HTTP  = 4'd7;
    localparam logic [3:0] LEN_HTTPS = 4'd8;
    localparam logic [3:0] LEN_VER   = 4'd8;
    localparam logic [3:0] LEN_CONN  = 4'd11;
    localparam logic [3:0] LEN_KEEP  = 4'd10;
    localparam logic [3:0] IDX_MAX   = 4'd15;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] idx;
        logic [1:0] mcand;
        logic       post;
        logic       linger;
        logic [1:0] hflags;
        logic [1:0] pflags;
    } hrhp_state_t;

    typedef struct packed {
        logic bad;
        logic done;
        logic echo;
    } hrhp_step_t;

    localparam hrhp_state_t STATE_RESET = '{
        phase:  PH_METHOD,
        idx:    4'd0,
        mcand:  2'b11,
        post:   1'b0,
        linger: 1'b0,
        hflags: 2'b00,
        pflags: 2'b00
    };

    function automatic logic [7:0] fold(input logic [7:0] c);
        fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    // Keyword tables hold the lower-case form of each character.
    function automatic logic [7:0] kw_get(input logic [3:0] i);
        unique case (i)
            4'd0:    kw_get = "g";
            4'd1:    kw_get = "e";
            4'd2:    kw_get = "t";
            default: kw_get = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] kw_post(input logic [3:0] i);
        unique case (i)
            4'd0:    kw_post = "p";
            4'd1:    kw_post = "o";
            4'd2:    kw_post = "s";
            4'd3:    kw_post = "t";
            default: kw_post = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] kw_https(input logic [3:0] i);
        unique case (i)
            4'd0:    kw_https = "h";
            4'd1:    kw_https = "t";
            4'd2:    kw_https = "t";
            4'd3:    kw_https = "p";
            4'd4:    kw_https = "s";
            4'd5:    kw_https = ":";
            4'd6:    kw_https = "/";
            4'd7:    kw_https = "/";
            default: kw_https = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] kw_http(input logic [3:0] i);
        unique case (i)
            4'd0:    kw_http = "h";
            4'd1:    kw_http = "t";
            4'd2:    kw_http = "t";
            4'd3:    kw_http = "p";
            4'd4:    kw_http = ":";
            4'd5:    kw_http = "/";
            4'd6:    kw_http = "/";
            default: kw_http = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] kw_ver(input logic [3:0] i);
        unique case (i)
            4'd0:    kw_ver = "h";
            4'd1:    kw_ver = "t";
            4'd2:    kw_ver = "t";
            4'd3:    kw_ver = "p";
            4'd4:    kw_ver = "/";
            4'd5:    kw_ver = "1";
            4'd6:    kw_ver = ".";
            4'd7:    kw_ver = "1";
            default: kw_ver = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] kw_conn(input logic [3:0] i);
        unique case (i)
            4'd0:    kw_conn = "c";
            4'd1:    kw_conn = "o";
            4'd2:    kw_conn = "n";
            4'd3:    kw_conn = "n";
            4'd4:    kw_conn = "e";
            4'd5:    kw_conn = "c";
            4'd6:    kw_conn = "t";
            4'd7:    kw_conn = "i";
            4'd8:    kw_conn = "o";
            4'd9:    kw_conn = "n";
            4'd10:   kw_conn = ":";
            default: kw_conn = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] kw_keep(input logic [3:0] i);
        unique case (i)
            4'd0:    kw_keep = "k";
            4'd1:    kw_keep = "e";
            4'd2:    kw_keep = "e";
            4'd3:    kw_keep = "p";
            4'd4:    kw_keep = "-";
            4'd5:    kw_keep = "a";
            4'd6:    kw_keep = "l";
            4'd7:    kw_keep = "i";
            4'd8:    kw_keep = "v";
            4'd9:    kw_keep = "e";
            default: kw_keep = 8'h00;
        endcase
    endfunction

endpackage

// ===== hdl/http_request_header_parser.sv =====
`timescale 1ns / 1ps
// Pipeline: a request is registered at the input, and its result is loaded into the
// output register when the output is empty or m_tready is high.
// Throughput: one byte per cycle unless m_tready stalls; parse state: one shallow step.
// Reset: aresetn is synchronous and active low; it empties both registers and
// returns the parser to the start of a request line with the status cleared.
// ----------------------------------------------------------------------------
// HTTP request header parser
// Parses an HTTP/1.1 request line and headers byte by byte and echoes the URL path.
// ----------------------------------------------------------------------------
module http_request_header_parser
    import hrhp_pkg::*;
#(
    parameter int BUFFER_BYTES = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_tuser,   // [0] clear
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] status, [2] is_post, [3] keep_alive,
                                   // [11:4] url_char, [15:12] zero
    output logic [0:0]  m_tuser    // [0] url_valid
);

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_BYTES);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_clear_reg;
    logic             out_valid_reg;
    logic [11:0]      out_data_reg;
    logic [11:0]      out_data_next;
    logic             out_url_reg;
    logic             out_url_next;

    hrhp_state_t      state_reg;
    hrhp_state_t      state_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic             cr_reg;
    logic             cr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    hrhp_state_t      base;
    hrhp_state_t      step_state;
    hrhp_step_t       step_res;
    logic [1:0]       base_status;
    logic             base_cr;
    logic [CNT_W-1:0] base_count;
    logic             eol;
    logic             advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};
    assign m_tuser  = out_url_reg;

    assign base        = in_clear_reg ? STATE_RESET : state_reg;
    assign base_status = in_clear_reg ? ST_MORE : status_reg;
    assign base_cr     = in_clear_reg ? 1'b0 : cr_reg;
    assign base_count  = in_clear_reg ? '0 : count_reg;
    assign eol         = base_cr && (in_byte_reg == CH_LF);

    hrhp_step u_step (
        .cur     (base),
        .in_byte (in_byte_reg),
        .eol     (eol),
        .nxt     (step_state),
        .res     (step_res)
    );

    always_comb begin
        state_next  = base;
        status_next = base_status;
        cr_next     = base_cr;
        count_next  = base_count;
        out_url_next = 1'b0;
        if (base_status == ST_MORE) begin
            if (base_count >= CNT_LIMIT) begin
                status_next = ST_TOO_LONG;
            end else begin
                count_next = base_count + 1'b1;
                priority if (base_cr) begin
                    cr_next = 1'b0;
                    if (eol) begin
                        state_next  = step_state;
                        status_next = step_res.bad ? ST_BAD
                                    : (step_res.done ? ST_COMPLETE : ST_MORE);
                    end else begin
                        status_next = ST_BAD;
                    end
                end else if (in_byte_reg == CH_CR) begin
                    cr_next = 1'b1;
                end else if (in_byte_reg == CH_LF) begin
                    status_next = ST_BAD;
                end else begin
                    state_next   = step_state;
                    status_next  = step_res.bad ? ST_BAD : ST_MORE;
                    out_url_next = step_res.echo;
                end
            end
        end
        out_data_next = {out_url_next ? in_byte_reg : 8'd0,
                         state_next.linger, state_next.post, status_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
            status_reg    <= ST_MORE;
            cr_reg        <= 1'b0;
            count_reg     <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                status_reg    <= status_next;
                cr_reg        <= cr_next;
                count_reg     <= count_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_clear_reg <= s_tuser[0];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
            out_url_reg  <= out_url_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[1:0] == ST_MORE)
        else $error("URL byte delivered with a final status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_clear_reg && status_reg != ST_MORE |=> status_reg == $past(status_reg))
        else $error("held status changed without a clear");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && out_url_next |=> state_reg.phase == PH_PATH)
        else $error("URL byte echoed outside the path field");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_LIMIT)
        else $error("byte count passed the buffer size");
`endif

endmodule

// ===== hdl/hrhp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request parser step logic
// Computes the next parse state for one ordinary byte or one line end.
// ----------------------------------------------------------------------------
module hrhp_step
    import hrhp_pkg::*;
(
    input  hrhp_state_t cur,
    input  logic [7:0]  in_byte,
    input  logic        eol,
    output hrhp_state_t nxt,
    output hrhp_step_t  res
);

    hrhp_state_t eff;
    logic [7:0]  fc;
    logic        blank;
    logic [3:0]  idx_inc;
    logic [3:0]  idx_sat;
    logic [1:0]  nf;
    logic [1:0]  nc;

    assign fc      = fold(in_byte);
    assign blank   = is_blank(in_byte);
    assign idx_sat = (eff.idx < IDX_MAX) ? eff.idx + 4'd1 : eff.idx;
    assign idx_inc = eff.idx + 4'd1;

    // A byte that opens a new field restarts the matching of that field.
    always_comb begin
        eff = cur;
        if (!eol) begin
            priority if (cur.phase == PH_GAP2 && !blank) begin
                eff.phase = PH_VERSION;
                eff.idx   = 4'd0;
            end else if (cur.phase == PH_HDR_START) begin
                eff.phase  = PH_HDR_NAME;
                eff.idx    = 4'd0;
                eff.hflags = 2'b01;
            end else if (cur.phase == PH_HDR_GAP && !blank) begin
                eff.phase  = PH_HDR_VALUE;
                eff.idx    = 4'd0;
                eff.hflags = 2'b10;
            end else if (cur.phase == PH_GAP1 && !blank && in_byte != CH_SLASH) begin
                eff.phase  = PH_PREFIX;
                eff.idx    = 4'd0;
                eff.pflags = 2'b11;
            end else begin
                eff = cur;
            end
        end
    end

    assign nf[0] = eff.pflags[0] && (eff.idx < LEN_HTTP) && (fc == kw_http(eff.idx));
    assign nf[1] = eff.pflags[1] && (eff.idx < LEN_HTTPS) && (fc == kw_https(eff.idx));
    assign nc[0] = eff.mcand[0] && (eff.idx < LEN_GET) && (fc == kw_get(eff.idx));
    assign nc[1] = eff.mcand[1] && (eff.idx < LEN_POST) && (fc == kw_post(eff.idx));

    always_comb begin
        nxt = eff;
        res = '0;
        if (eol) begin
            unique case (eff.phase)
                PH_VERSION: begin
                    if (eff.idx == LEN_VER) begin
                        nxt.phase = PH_HDR_START;
                    end else begin
                        res.bad = 1'b1;
                    end
                end
                PH_HDR_START: begin
                    res.done = 1'b1;
                end
                PH_HDR_NAME, PH_HDR_GAP: begin
                    nxt.phase = PH_HDR_START;
                end
                PH_HDR_VALUE: begin
                    if (eff.hflags[1] && eff.idx == LEN_KEEP) begin
                        nxt.linger = 1'b1;
                    end
                    nxt.phase = PH_HDR_START;
                end
                default: begin
                    res.bad = 1'b1;
                end
            endcase
        end else begin
            unique case (eff.phase)
                PH_METHOD: begin
                    if (blank) begin
                        priority if (eff.idx == LEN_GET && eff.mcand[0]) begin
                            nxt.phase = PH_GAP1;
                        end else if (eff.idx == LEN_POST && eff.mcand[1]) begin
                            nxt.post  = 1'b1;
                            nxt.phase = PH_GAP1;
                        end else begin
                            res.bad = 1'b1;
                        end
                    end else begin
                        nxt.mcand = nc;
                        nxt.idx   = idx_sat;
                        res.bad   = (nc == 2'b00);
                    end
                end
                PH_GAP1: begin
                    if (in_byte == CH_SLASH) begin
                        res.echo  = 1'b1;
                        nxt.phase = PH_PATH;
                    end
                end
                PH_PREFIX: begin
                    if (blank) begin
                        res.bad = 1'b1;
                    end else begin
                        nxt.pflags = nf;
                        nxt.idx    = idx_sat;
                        if (nf == 2'b00) begin
                            res.bad = 1'b1;
                        end else if ((nf[0] && idx_sat == LEN_HTTP)
                                     || (nf[1] && idx_sat == LEN_HTTPS)) begin
                            nxt.phase = PH_HOST;
                        end
                    end
                end
                PH_HOST: begin
                    if (blank) begin
                        res.bad = 1'b1;
                    end else if (in_byte == CH_SLASH) begin
                        res.echo  = 1'b1;
                        nxt.phase = PH_PATH;
                    end
                end
                PH_PATH: begin
                    if (blank) begin
                        nxt.phase = PH_GAP2;
                    end else begin
                        res.echo = 1'b1;
                    end
                end
                PH_GAP2, PH_HDR_GAP: begin
                    nxt = eff;
                end
                PH_VERSION: begin
                    if (eff.idx < LEN_VER && fc == kw_ver(eff.idx)) begin
                        nxt.idx = idx_inc;
                    end else begin
                        res.bad = 1'b1;
                    end
                end
                PH_HDR_NAME: begin
                    if (eff.hflags[0] && eff.idx < LEN_CONN && fc == kw_conn(eff.idx)) begin
                        nxt.idx = idx_inc;
                        if (idx_inc == LEN_CONN) begin
                            nxt.phase = PH_HDR_GAP;
                        end
                    end else begin
                        nxt.hflags = 2'b00;
                    end
                end
                PH_HDR_VALUE: begin
                    if (eff.hflags[1] && eff.idx < LEN_KEEP && fc == kw_keep(eff.idx)) begin
                        nxt.idx = idx_inc;
                    end else begin
                        nxt.hflags = 2'b00;
                    end
                end
                default: begin
                    res.bad = 1'b1;
                end
            endcase
        end
    end

endmodule
